/* rtl/sgp_pkg.sv */
// ----------------------------------------------------------------------------
// sgp_pkg: shared types for the Sophie Germain prime tester
// Status word that the remainder unit returns to the sequencer.
// ----------------------------------------------------------------------------
package sgp_pkg;

  // Smallest prime; values below it are never prime
  localparam int unsigned SMALLEST_PRIME = 2;

  // Remainder unit status, valid for one cycle when done is high
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

/* rtl/sgp_if.sv */
// ----------------------------------------------------------------------------
// sgp_in_if / sgp_out_if: valid/ready channels of the prime tester
// Candidate channel and result channel, each with a source and a sink side.
// ----------------------------------------------------------------------------
interface sgp_in_if #(
  parameter int CANDIDATE_BITS = 16
) ();
  logic                      valid;
  logic                      ready;
  logic [CANDIDATE_BITS-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface sgp_out_if #(
  parameter int CANDIDATE_BITS = 16
) ();
  logic                    valid;
  logic                    ready;
  logic                    candidate_is_prime;
  logic                    is_sophie_germain;
  logic [CANDIDATE_BITS:0] partner_value;

  modport source (output valid, output candidate_is_prime, output is_sophie_germain,
                  output partner_value, input ready);
  modport sink   (input valid, input candidate_is_prime, input is_sophie_germain,
                  input partner_value, output ready);
endinterface

/* rtl/sgp_div.sv */
// ----------------------------------------------------------------------------
// sgp_div: bit-serial restoring remainder unit
// Computes dividend mod divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sgp_div #(
  parameter int WIDTH = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WIDTH-1:0]  dividend_i,
  input  logic [WIDTH-1:0]  divisor_i,
  output sgp_pkg::div_stat_t stat_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] sh_q;
  logic [WIDTH:0]   trial;

  // Shift the next dividend bit into the partial remainder
  assign trial = {rem_q, sh_q[WIDTH-1]};

  // Load on start, then count the remainder steps and flag done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= dividend_i;
    end else if (busy_q) begin
      sh_q <= sh_q << 1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_q <= WIDTH'(trial - {1'b0, divisor_i});
      end else begin
        rem_q <= trial[WIDTH-1:0];
      end
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

/* rtl/sophie_germain_prime_test.sv */
// ----------------------------------------------------------------------------
// sophie_germain_prime_test: trial-division Sophie Germain prime tester
// Decides whether p is prime and whether p and 2p+1 are both prime.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one candidate p per item; out_o returns one result item with
//   candidate_is_prime, is_sophie_germain and partner_value = 2p+1.
//   in_i.ready is high only while the sequencer is idle; one candidate is
//   processed at a time.
// Sequence:
//   Each trial divisor d (2, 3, ... while d*d <= n) takes one bound check,
//   one start of the remainder unit, CANDIDATE_BITS+1 remainder steps and a
//   read of the status. p is tested first; 2p+1 only if p is prime. For the
//   default width that is up to 254 divisors for p and 361 for 2p+1; values
//   below 2 are judged not prime without any trial divisor.
// Reset:
//   rst_ni clears the sequencer and the result valid; no stores to clear.
// Stall:
//   A finished result sits in the output register until out_o.ready; the
//   next candidate is accepted meanwhile and is held only if its own result
//   is ready before the previous one has been taken.
// ----------------------------------------------------------------------------
module sophie_germain_prime_test #(
  parameter int CANDIDATE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sgp_in_if.sink       in_i,
  sgp_out_if.source    out_o
);

  localparam int PW = CANDIDATE_BITS + 1;  // tested value width
  localparam int SW = PW + 2;              // running square width

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BOUND,
    S_DIV,
    S_VERDICT,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [PW-1:0]        n_q;
  logic [PW-1:0]        partner_q;
  logic [PW-1:0]        d_q;
  logic [SW-1:0]        sq_q;
  logic                 phase_q;
  logic                 verdict_q;
  logic                 p_prime_q;
  logic                 div_start_q;
  logic                 out_valid_q;
  logic                 out_prime_q;
  logic                 out_sg_q;
  logic [PW-1:0]        out_partner_q;
  sgp_pkg::div_stat_t   div_stat;

  // Shared remainder unit: n mod d
  sgp_div #(
    .WIDTH (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .stat_o     (div_stat)
  );

  assign in_i.ready = (state_q == S_IDLE);

  // Sequence trial division over p, then over 2p+1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      verdict_q   <= 1'b0;
      p_prime_q   <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            n_q       <= {1'b0, in_i.candidate};
            partner_q <= {in_i.candidate, 1'b1};
            phase_q   <= 1'b0;
            state_q   <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Drop values below two, else start at d = 2
          if (n_q < PW'(sgp_pkg::SMALLEST_PRIME)) begin
            verdict_q <= 1'b0;
            state_q   <= S_VERDICT;
          end else begin
            d_q     <= PW'(sgp_pkg::SMALLEST_PRIME);
            sq_q    <= SW'(sgp_pkg::SMALLEST_PRIME * sgp_pkg::SMALLEST_PRIME);
            state_q <= S_BOUND;
          end
        end
        S_BOUND: begin
          // Past the square root: no divisor found
          if (sq_q > {2'b00, n_q}) begin
            verdict_q <= 1'b1;
            state_q   <= S_VERDICT;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (div_stat.rem_zero) begin
              verdict_q <= 1'b0;
              state_q   <= S_VERDICT;
            end else begin
              // Advance d and keep sq = d*d
              sq_q    <= sq_q + {1'b0, d_q, 1'b1};
              d_q     <= d_q + PW'(1);
              state_q <= S_BOUND;
            end
          end
        end
        S_VERDICT: begin
          if (!phase_q) begin
            p_prime_q <= verdict_q;
            if (verdict_q) begin
              n_q     <= partner_q;
              phase_q <= 1'b1;
              state_q <= S_CHECK;
            end else begin
              state_q <= S_EMIT;
            end
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_prime_q   <= p_prime_q;
            out_sg_q      <= phase_q & verdict_q;
            out_partner_q <= partner_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.candidate_is_prime = out_prime_q;
  assign out_o.is_sophie_germain  = out_sg_q;
  assign out_o.partner_value      = out_partner_q;

endmodule
